[src/lgep_pkg.sv]
// ----------------------------------------------------------------------------
// lgep_pkg - shared types and constants of the luminance glow pipeline
// Pixel words, inter-stage payloads, register codes and fixed-point constants.
// ----------------------------------------------------------------------------
package lgep_pkg;

  localparam int CFG_W   = 16;
  localparam int CHAN_W  = 8;
  localparam int LUM_W   = 24;  // Q8.16 luminance, 0..16711680
  localparam int T_W     = 17;  // Q0.16 value in 0..1.0 inclusive
  localparam int SLOPE_W = 18;  // 3.0 - 2t in Q0.16, up to 196608

  localparam logic [LUM_W-1:0]   LUMA_W_RED   = 24'd19595;
  localparam logic [LUM_W-1:0]   LUMA_W_GREEN = 24'd38470;
  localparam logic [LUM_W-1:0]   LUMA_W_BLUE  = 24'd7471;
  localparam logic [T_W-1:0]     Q16_ONE      = 17'h10000;
  localparam logic [SLOPE_W-1:0] Q16_THREE    = 18'd196608;
  localparam logic [CHAN_W+T_W-1:0] Q16_HALF  = 25'd32768;
  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'd255;

  localparam logic [CFG_W-1:0] EDGE_LOW_RST  = 16'd19584;
  localparam logic [CFG_W-1:0] RAMP_GAIN_RST = 16'd514;

  typedef enum logic [0:0] {
    REG_EDGE_LOW  = 1'b0,
    REG_RAMP_GAIN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } pix_out_t;

  // Luminance above the low edge, zero when at or below it
  typedef struct packed {
    pix_in_t          pix;
    logic [LUM_W-1:0] diff;
  } luma_t;

  typedef struct packed {
    pix_in_t        pix;
    logic [T_W-1:0] glow;
  } glow_t;

endpackage

[src/lgep_luma.sv]
// ----------------------------------------------------------------------------
// lgep_luma - luminance and edge subtract
// Two stages: weighted sum of the channels, then distance above the low edge.
// ----------------------------------------------------------------------------
module lgep_luma (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  lgep_pkg::pix_in_t              up_data,
  input  logic [lgep_pkg::CFG_W-1:0]     edge_low,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output lgep_pkg::luma_t                dn_data
);
  import lgep_pkg::*;

  logic             valid_a;
  pix_in_t          pix_a;
  logic [LUM_W-1:0] lum_a;
  logic [LUM_W-1:0] lum_next;
  logic [LUM_W-1:0] base;
  logic             ready_a;
  logic             ready_b;

  assign ready_b  = !dn_valid || dn_ready;
  assign ready_a  = !valid_a || ready_b;
  assign up_ready = ready_a;

  assign lum_next = LUM_W'(up_data.red_in) * LUMA_W_RED
                  + LUM_W'(up_data.green_in) * LUMA_W_GREEN
                  + LUM_W'(up_data.blue_in) * LUMA_W_BLUE;
  assign base = {edge_low, 8'h00};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_a) begin
      valid_a <= up_valid;
    end
    if (ready_a && up_valid) begin
      pix_a <= up_data;
      lum_a <= lum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ready_b) begin
      dn_valid <= valid_a;
    end
    if (ready_b && valid_a) begin
      dn_data.pix  <= pix_a;
      dn_data.diff <= (lum_a > base) ? lum_a - base : '0;
    end
  end

endmodule

[src/lgep_ramp.sv]
// ----------------------------------------------------------------------------
// lgep_ramp - ramp and smoothstep
// Three stages: gain multiply, clamp and square, cubic shaping to the glow.
// ----------------------------------------------------------------------------
module lgep_ramp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  lgep_pkg::luma_t                up_data,
  input  logic [lgep_pkg::CFG_W-1:0]     ramp_gain,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output lgep_pkg::glow_t                dn_data
);
  import lgep_pkg::*;

  localparam int PROD_W = LUM_W + CFG_W;

  logic                 valid_c;
  logic                 valid_d;
  pix_in_t              pix_c;
  pix_in_t              pix_d;
  logic [LUM_W-1:0]     ramp_c;
  logic [T_W-1:0]       t2_d;
  logic [SLOPE_W-1:0]   slope_d;
  logic [PROD_W-1:0]    prod_next;
  logic [T_W-1:0]       t_sat;
  logic [2*T_W-1:0]     sq_next;
  logic [T_W+SLOPE_W-1:0] cube_next;
  logic                 ready_c;
  logic                 ready_d;
  logic                 ready_e;

  assign ready_e  = !dn_valid || dn_ready;
  assign ready_d  = !valid_d || ready_e;
  assign ready_c  = !valid_c || ready_d;
  assign up_ready = ready_c;

  assign prod_next = PROD_W'(up_data.diff) * PROD_W'(ramp_gain);
  // saturate t at 1.0
  assign t_sat     = (ramp_c > LUM_W'(Q16_ONE)) ? Q16_ONE : ramp_c[T_W-1:0];
  assign sq_next   = (2*T_W)'(t_sat) * (2*T_W)'(t_sat);
  assign cube_next = (T_W+SLOPE_W)'(t2_d) * (T_W+SLOPE_W)'(slope_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
      valid_d <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (ready_c) begin
        valid_c <= up_valid;
      end
      if (ready_d) begin
        valid_d <= valid_c;
      end
      if (ready_e) begin
        dn_valid <= valid_d;
      end
    end
    if (ready_c && up_valid) begin
      pix_c  <= up_data.pix;
      ramp_c <= prod_next[PROD_W-1:16];
    end
    if (ready_d && valid_c) begin
      pix_d   <= pix_c;
      t2_d    <= sq_next[T_W+15:16];
      slope_d <= Q16_THREE - {t_sat, 1'b0};
    end
    if (ready_e && valid_d) begin
      dn_data.pix  <= pix_d;
      dn_data.glow <= cube_next[T_W+15:16];
    end
  end

endmodule

[src/lgep_scale.sv]
// ----------------------------------------------------------------------------
// lgep_scale - channel scaling and output register
// One stage: each channel times the glow, rounded half up; alpha forced opaque.
// ----------------------------------------------------------------------------
module lgep_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  lgep_pkg::glow_t     up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output lgep_pkg::pix_out_t  dn_data
);
  import lgep_pkg::*;

  localparam int SC_W = CHAN_W + T_W;

  logic [SC_W-1:0] red_sc;
  logic [SC_W-1:0] green_sc;
  logic [SC_W-1:0] blue_sc;

  assign up_ready = !dn_valid || dn_ready;

  assign red_sc   = SC_W'(up_data.pix.red_in) * SC_W'(up_data.glow) + Q16_HALF;
  assign green_sc = SC_W'(up_data.pix.green_in) * SC_W'(up_data.glow) + Q16_HALF;
  assign blue_sc  = SC_W'(up_data.pix.blue_in) * SC_W'(up_data.glow) + Q16_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    // glow never exceeds 1.0, so the rounded product stays within a byte
    if (up_ready && up_valid) begin
      dn_data.red_out   <= red_sc[CHAN_W+15:16];
      dn_data.green_out <= green_sc[CHAN_W+15:16];
      dn_data.blue_out  <= blue_sc[CHAN_W+15:16];
      dn_data.alpha_out <= ALPHA_OPAQUE;
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_glow_black: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_ready && up_data.glow == '0) |=>
      (dn_data.red_out == '0 && dn_data.green_out == '0 && dn_data.blue_out == '0))
    else $error("zero glow did not give a black pixel");

  a_full_glow_pass: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_ready && up_data.glow == Q16_ONE) |=>
      (dn_data.red_out == $past(up_data.pix.red_in) &&
       dn_data.green_out == $past(up_data.pix.green_in) &&
       dn_data.blue_out == $past(up_data.pix.blue_in)))
    else $error("full glow did not pass the pixel through");

  a_glow_range: assert property (@(posedge clk) disable iff (rst)
    up_valid |-> up_data.glow <= Q16_ONE)
    else $error("glow factor above 1.0");
`endif

endmodule

[src/luminance_glow_emissive_pixel.sv]
// ----------------------------------------------------------------------------
// luminance_glow_emissive_pixel - smoothstep glow mask on luminance
// Scales an RGB8 pixel by a smoothstep of its Rec.601 luminance; alpha opaque.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------
//  src     | in        | src_valid / src_stall | src_data  (pix_in_t)
//  dst     | out       | dst_valid / dst_stall | dst_data  (pix_out_t)
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One word per clock in and out, sustained while dst_stall is low. The path
//  from src to dst runs through six register stages: two luminance
//  stages, three ramp and smoothstep stages (one multiply each), one scaling
//  stage.
//  Each stage advances when its successor is empty or advancing, so bubbles
//  collapse and src is taken while a finished word waits on dst, if some stage is empty.
//  rst is synchronous: it empties the pipeline and loads the register
//  defaults; cfg_ready is always high.
//
module luminance_glow_emissive_pixel (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      src_valid,
  output logic                      src_stall,
  input  lgep_pkg::pix_in_t         src_data,
  output logic                      dst_valid,
  input  logic                      dst_stall,
  output lgep_pkg::pix_out_t        dst_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  lgep_pkg::cfg_reg_t        cfg_index,
  input  logic [lgep_pkg::CFG_W-1:0] cfg_data
);
  import lgep_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] edge_low;
  logic [CFG_W-1:0] ramp_gain;

  // Inter-module handshakes
  logic    luma_in_ready;
  logic    luma_valid;
  logic    luma_ready;
  luma_t   luma_data;
  logic    glow_valid;
  logic    glow_ready;
  glow_t   glow_data;

  // Register writes never stall; values are to be changed only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_low  <= EDGE_LOW_RST;
      ramp_gain <= RAMP_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EDGE_LOW:  edge_low  <= cfg_data;
        REG_RAMP_GAIN: ramp_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stall the source whenever the first stage cannot advance
  assign src_stall = !luma_in_ready;

  lgep_luma u_luma (
    .clk      (clk),
    .rst      (rst),
    .up_valid (src_valid),
    .up_ready (luma_in_ready),
    .up_data  (src_data),
    .edge_low (edge_low),
    .dn_valid (luma_valid),
    .dn_ready (luma_ready),
    .dn_data  (luma_data)
  );

  lgep_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (luma_valid),
    .up_ready  (luma_ready),
    .up_data   (luma_data),
    .ramp_gain (ramp_gain),
    .dn_valid  (glow_valid),
    .dn_ready  (glow_ready),
    .dn_data   (glow_data)
  );

  // Output register lives in the scaling stage; hold it while dst stalls
  lgep_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (glow_valid),
    .up_ready (glow_ready),
    .up_data  (glow_data),
    .dn_valid (dst_valid),
    .dn_ready (!dst_stall),
    .dn_data  (dst_data)
  );

`ifndef NO_ASSERTIONS
  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> dst_data.alpha_out == ALPHA_OPAQUE)
    else $error("alpha not opaque on an output word");

  a_reset_defaults: assert property (@(posedge clk)
    $past(rst) |-> (edge_low == EDGE_LOW_RST && ramp_gain == RAMP_GAIN_RST))
    else $error("registers not at defaults after reset");

  a_edge_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_EDGE_LOW) |=>
      edge_low == $past(cfg_data))
    else $error("low edge write not taken");
`endif

endmodule
